[rtl/pru_pkg.sv]
package pru_pkg;

  // Field widths of the stream payload
  localparam int unsigned ENTRY_W      = 3;
  localparam int unsigned MAX_ELEMENTS = 8;
  localparam int unsigned PERM_W       = ENTRY_W * MAX_ELEMENTS;
  localparam int unsigned RANK_W       = 16;
  localparam int unsigned FACT_W       = 17;

  localparam int unsigned DEFAULT_ELEMENTS = 8;

  // Request selector codes
  localparam logic REQ_RANK   = 1'b0;
  localparam logic REQ_UNRANK = 1'b1;

  // Factorials 0! .. 8!
  localparam logic [FACT_W-1:0] FACT [0:MAX_ELEMENTS] = '{
    17'd1, 17'd1, 17'd2, 17'd6, 17'd24, 17'd120, 17'd720, 17'd5040, 17'd40320
  };

  // One pipeline slot
  typedef struct packed {
    logic              req;   // request kind
    logic              err;   // unrank rank out of range
    logic [RANK_W-1:0] acc;   // rank sum (rank) or remaining rank (unrank)
    logic [PERM_W-1:0] perm;  // input permutation (rank)
    logic [PERM_W-1:0] pool;  // unused values, in order (unrank)
    logic [PERM_W-1:0] res;   // rebuilt permutation (unrank)
  } stage_t;

endpackage

[rtl/permutation_rank_unrank_unit.sv]
// Channel   Dir  Handshake                 Payload
// s_axis    in   s_axis_tvalid/tready      tdata: perm_in, rank_in; tuser: req_type
// m_axis    out  m_axis_tvalid/tready      tdata: perm_out, rank_out, range_error
//
// One input register, then one stage per position. While output back pressure
// does not stall it, one transaction enters per cycle; each position stage holds
// one 8-way compare bank and one constant-factorial multiply or divide-by-compare.
// Reset clears only the valid bits of the stages.
// A stage loads whenever it is empty or the stage after it moves, so bubbles
// collapse under back pressure and nothing is dropped or repeated.
module permutation_rank_unrank_unit #(
  parameter int unsigned ELEMENTS = pru_pkg::DEFAULT_ELEMENTS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // [23:0] perm_in, [39:24] rank_in
  input  logic [0:0]  s_axis_tuser,   // [0] req_type
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata    // [23:0] perm_out, [39:24] rank_out,
                                      // [40] range_error, [47:41] zero
);

  localparam int unsigned PW = pru_pkg::PERM_W;
  localparam int unsigned RW = pru_pkg::RANK_W;
  localparam int unsigned EW = pru_pkg::ENTRY_W;
  localparam int unsigned ME = pru_pkg::MAX_ELEMENTS;

  pru_pkg::stage_t       stg_q [0:ELEMENTS];
  pru_pkg::stage_t       stg_d [0:ELEMENTS];
  logic [ELEMENTS:0]     vld_q;
  logic [ELEMENTS:0]     rdy;

  // Ready chain from the output back
  assign rdy[ELEMENTS] = !vld_q[ELEMENTS] || m_axis_tready;
  for (genvar k = 0; k < ELEMENTS; k++) begin : g_rdy
    assign rdy[k] = !vld_q[k] || rdy[k+1];
  end
  assign s_axis_tready = rdy[0];

  // Input stage: range check and pool setup
  always_comb begin
    stg_d[0].req  = s_axis_tuser[0];
    stg_d[0].err  = (s_axis_tuser[0] == pru_pkg::REQ_UNRANK) &&
                    ({1'b0, s_axis_tdata[39:24]} >= pru_pkg::FACT[ELEMENTS]);
    stg_d[0].acc  = (s_axis_tuser[0] == pru_pkg::REQ_UNRANK) ? s_axis_tdata[39:24] : '0;
    stg_d[0].perm = s_axis_tdata[23:0];
    for (int i = 0; i < ME; i++) begin
      stg_d[0].pool[i*EW +: EW] = EW'(i);
    end
    stg_d[0].res  = '0;
  end

  // One stage per position
  for (genvar k = 1; k <= ELEMENTS; k++) begin : g_pos
    localparam int unsigned POS = k - 1;
    localparam logic [19:0] F   = 20'(pru_pkg::FACT[ELEMENTS-1-POS]);

    logic [EW-1:0] ent;
    logic [3:0]    smaller;
    logic [2:0]    quo;
    logic [19:0]   sub;
    logic [EW-1:0] pick;

    always_comb begin
      stg_d[k] = stg_q[k-1];
      ent      = stg_q[k-1].perm[POS*EW +: EW];
      // count later entries that are smaller
      smaller  = '0;
      for (int j = 0; j < ME; j++) begin
        if (j > POS && j < ELEMENTS && ent > stg_q[k-1].perm[j*EW +: EW]) begin
          smaller = smaller + 4'd1;
        end
      end
      // quotient by constant factorial through compares
      quo = '0;
      for (int m = 1; m < ME; m++) begin
        if (20'(stg_q[k-1].acc) >= 20'(m) * F) begin
          quo = quo + 3'd1;
        end
      end
      sub  = 20'(quo) * F;
      pick = stg_q[k-1].pool[quo*EW +: EW];
      if (stg_q[k-1].req == pru_pkg::REQ_UNRANK) begin
        stg_d[k].acc = stg_q[k-1].acc - sub[RW-1:0];
        stg_d[k].res[POS*EW +: EW] = pick;
        // take the chosen value out of the pool
        for (int m = 0; m < ME - 1; m++) begin
          if (m >= quo) begin
            stg_d[k].pool[m*EW +: EW] = stg_q[k-1].pool[(m+1)*EW +: EW];
          end
        end
      end else begin
        stg_d[k].acc = stg_q[k-1].acc + RW'(F[RW-1:0] * RW'(smaller));
      end
    end
  end

  // Stage registers: valid bits reset, payload does not
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q[0] <= rdy[0] ? s_axis_tvalid : vld_q[0];
      for (int k = 1; k <= ELEMENTS; k++) begin
        if (rdy[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      stg_q[0] <= stg_d[0];
    end
    for (int k = 1; k <= ELEMENTS; k++) begin
      if (rdy[k]) begin
        stg_q[k] <= stg_d[k];
      end
    end
  end

  // Output formatting
  logic unrank_ok;
  assign unrank_ok     = (stg_q[ELEMENTS].req == pru_pkg::REQ_UNRANK) && !stg_q[ELEMENTS].err;
  assign m_axis_tvalid = vld_q[ELEMENTS];
  assign m_axis_tdata  = {7'd0,
                          stg_q[ELEMENTS].err &&
                            (stg_q[ELEMENTS].req == pru_pkg::REQ_UNRANK),
                          (stg_q[ELEMENTS].req == pru_pkg::REQ_RANK) ?
                            stg_q[ELEMENTS].acc : RW'(0),
                          unrank_ok ? stg_q[ELEMENTS].res : PW'(0)};

  // Checks
  a_stall_only_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
    else $error("input stalled without output back pressure");

  a_err_zero_perm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[40]) |-> (m_axis_tdata[39:0] == 40'd0))
    else $error("range error with nonzero result");

  a_rank_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ({1'b0, m_axis_tdata[39:24]} < pru_pkg::FACT[ELEMENTS]))
    else $error("rank out of bound");

  a_out_moves_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready && vld_q[ELEMENTS-1]) |=> m_axis_tvalid)
    else $error("pipeline lost a transaction");

endmodule

[sim/tb_permutation_rank_unrank_unit.sv]
module tb_permutation_rank_unrank_unit;

  // Size used by the unit, saturated to 1..8 here; the unit itself does not saturate
  localparam int unsigned N_ELEM = (pru_pkg::DEFAULT_ELEMENTS < 1) ? 1 :
                                   (pru_pkg::DEFAULT_ELEMENTS > 8) ? 8 :
                                   pru_pkg::DEFAULT_ELEMENTS;
  localparam int unsigned RANDOM_REQUESTS = 450;
  localparam int unsigned CYCLE_LIMIT     = 200000;
  localparam int unsigned DRAIN_CYCLES    = N_ELEM + 8;

  // Result layout, same as m_axis_tdata from the highest bit down
  typedef struct packed {
    logic [6:0]  pad;
    logic        range_error;
    logic [15:0] rank_out;
    logic [23:0] perm_out;
  } conv_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;  // [23:0] perm_in, [39:24] rank_in
  logic [0:0]  s_axis_tuser = '0;  // [0] req_type
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;       // [23:0] perm_out, [39:24] rank_out, [40] range_error

  int unsigned cycle_count = 0;
  int unsigned burst_left = 0;
  logic [31:0] stall_phase = '0;
  logic [1:0]  stall_mode = '0;

  // Lehmer-code predictor and queue of expected conversions
  class conversion_board;
    conv_result_t pending[$];
    int unsigned  mismatches = 0;

    function int unsigned factorial(int unsigned k);
      int unsigned f;
      f = 1;
      for (int unsigned j = 2; j <= k; j++) f *= j;
      return f;
    endfunction

    // Sum of (remaining length)! times count of smaller later entries
    function logic [15:0] rank_of(logic [23:0] perm);
      int unsigned total;
      int unsigned smaller;
      total = 0;
      for (int i = 0; i < N_ELEM; i++) begin
        smaller = 0;
        for (int j = i + 1; j < N_ELEM; j++)
          if (perm[3*i +: 3] > perm[3*j +: 3]) smaller++;
        total += factorial(N_ELEM - 1 - i) * smaller;
      end
      return total[15:0];
    endfunction

    // Pick entries out of the ordered list of unused values
    function logic [23:0] unrank_of(int unsigned r);
      logic [2:0]  pool [8];
      logic [23:0] perm_bits;
      int unsigned f;
      int unsigned q;
      for (int k = 0; k < 8; k++) pool[k] = k[2:0];
      perm_bits = '0;
      for (int i = 0; i < N_ELEM; i++) begin
        f = factorial(N_ELEM - 1 - i);
        q = r / f;
        r -= q * f;
        if (q > 7) q = 7;
        perm_bits[3*i +: 3] = pool[q];
        for (int k = q; k < 7; k++) pool[k] = pool[k+1];
      end
      return perm_bits;
    endfunction

    function void note_request(logic req, logic [23:0] perm, logic [15:0] rank);
      conv_result_t want;
      want = '0;
      if (req == pru_pkg::REQ_RANK) want.rank_out = rank_of(perm);
      else if (rank >= factorial(N_ELEM)) want.range_error = 1'b1;
      else want.perm_out = unrank_of(rank);
      pending.push_back(want);
    endfunction

    task report(string what, logic [47:0] got, logic [47:0] want);
      $display("%0t mismatch on %s: got %0h expected %0h", $time, what, got, want);
      mismatches++;
    endtask

    task check_result(logic [47:0] tdata);
      conv_result_t got;
      conv_result_t want;
      got = tdata;
      if (pending.size() == 0) begin
        report("unexpected transaction", tdata, '0);
        return;
      end
      want = pending.pop_front();
      if (got.perm_out != want.perm_out)
        report("perm_out", 48'(got.perm_out), 48'(want.perm_out));
      if (got.rank_out != want.rank_out)
        report("rank_out", 48'(got.rank_out), 48'(want.rank_out));
      if (got.range_error != want.range_error)
        report("range_error", 48'(got.range_error), 48'(want.range_error));
      if (got.pad != want.pad) report("pad bits", 48'(got.pad), 48'(want.pad));
    endtask
  endclass

  conversion_board board = new();

  permutation_rank_unrank_unit #(
    .ELEMENTS(pru_pkg::DEFAULT_ELEMENTS)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always #10 clk_i = ~clk_i;

  // Run watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Receiver back pressure: a new random mode is drawn whenever stall_phase[5:0] is zero
  always @(posedge clk_i) begin
    stall_phase <= stall_phase + 1;
    if (stall_phase[5:0] == 0) stall_mode <= 2'($urandom_range(0, 3));
    case (stall_mode)
      2'd0: m_axis_tready <= 1'b1;
      2'd1: m_axis_tready <= ($urandom_range(0, 1) == 0);
      2'd2: m_axis_tready <= (stall_phase[1:0] == 0);
      default: m_axis_tready <= (stall_phase[3:0] == 0);
    endcase
  end

  // Transaction monitors on both channels
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready)
        board.note_request(s_axis_tuser[0], s_axis_tdata[23:0], s_axis_tdata[39:24]);
      if (m_axis_tvalid && m_axis_tready)
        board.check_result(m_axis_tdata);
    end
  end

  // Hold one request until the unit takes it
  task automatic apply_request(logic req, logic [23:0] perm, logic [15:0] rank);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= req;
    s_axis_tdata  <= {rank, perm};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Bursts of random length separated by random gaps
  task automatic push_request(logic req, logic [23:0] perm, logic [15:0] rank);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    apply_request(req, perm, rank);
    burst_left--;
  endtask

  task automatic wait_for_drain();
    s_axis_tvalid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk_i);
  endtask

  // Fisher-Yates shuffle of 0..7
  function automatic logic [23:0] shuffled_perm();
    logic [2:0]  vals [8];
    logic [2:0]  tmp;
    logic [23:0] perm_bits;
    int unsigned j;
    for (int k = 0; k < 8; k++) vals[k] = k[2:0];
    for (int k = 7; k > 0; k--) begin
      j = $urandom_range(0, k);
      tmp = vals[k];
      vals[k] = vals[j];
      vals[j] = tmp;
    end
    for (int k = 0; k < 8; k++) perm_bits[3*k +: 3] = vals[k];
    return perm_bits;
  endfunction

  initial begin
    int unsigned pick;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: identity, reverse, duplicates, bounds of the rank range
    push_request(pru_pkg::REQ_RANK, 24'hFAC688, 16'($urandom));
    push_request(pru_pkg::REQ_RANK, 24'h053977, 16'($urandom));
    push_request(pru_pkg::REQ_RANK, 24'h000000, 16'hFFFF);
    push_request(pru_pkg::REQ_RANK, 24'hFFFFFF, 16'h0000);
    push_request(pru_pkg::REQ_RANK, 24'($urandom), 16'($urandom));
    push_request(pru_pkg::REQ_RANK, shuffled_perm(), 16'($urandom));
    push_request(pru_pkg::REQ_UNRANK, 24'hFFFFFF, 16'd0);
    push_request(pru_pkg::REQ_UNRANK, 24'h000000, 16'd1);
    push_request(pru_pkg::REQ_UNRANK, 24'($urandom), 16'd5039);
    push_request(pru_pkg::REQ_UNRANK, 24'($urandom), 16'd5040);
    push_request(pru_pkg::REQ_UNRANK, 24'($urandom), 16'd40319);
    push_request(pru_pkg::REQ_UNRANK, 24'($urandom), 16'd40320);
    push_request(pru_pkg::REQ_UNRANK, 24'($urandom), 16'd40321);
    push_request(pru_pkg::REQ_UNRANK, 24'($urandom), 16'hFFFF);
    push_request(pru_pkg::REQ_UNRANK, 24'($urandom), 16'($urandom_range(0, 40319)));

    // Let the pipeline empty completely once
    wait_for_drain();

    // Random: mostly real permutations and in-range ranks
    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 40)
        push_request(pru_pkg::REQ_RANK, shuffled_perm(), 16'($urandom));
      else if (pick < 55)
        push_request(pru_pkg::REQ_RANK, 24'($urandom), 16'($urandom));
      else if (pick < 90)
        push_request(pru_pkg::REQ_UNRANK, 24'($urandom), 16'($urandom_range(0, 40319)));
      else
        push_request(pru_pkg::REQ_UNRANK, 24'($urandom),
                     16'($urandom_range(40320, 65535)));
    end

    wait_for_drain();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (board.mismatches == 0 && board.pending.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
